// ===== src/bswc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the bucketed sliding window counter.
package bswc_pkg;

  localparam int BUCKETS      = 64;
  localparam int UNIT_SECONDS = 64;

  localparam int ADDR_W   = $clog2(BUCKETS);
  localparam int CNT_W    = $clog2(BUCKETS + 1);
  localparam int BUCKET_W = 16;
  localparam int TOTAL_W  = 22;
  localparam int TIME_W   = 32;

  localparam logic [TIME_W-1:0]  WIN_SPAN  = TIME_W'(BUCKETS * UNIT_SECONDS);
  localparam logic [TIME_W-1:0]  UNIT_T    = TIME_W'(UNIT_SECONDS);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(BUCKETS - 1);
  localparam logic [CNT_W-1:0]   BUCKETS_C = CNT_W'(BUCKETS);

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_COUNT   = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADV  = 5'b00010,
    ST_QRY  = 5'b00100,
    ST_CNT  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

// ===== src/bucketed_sliding_window_counter_core.sv =====
`timescale 1ns / 1ps
// Top level of the bucketed sliding window event-rate counter.
//
//   channel  signals                                          direction
//   in       in_valid in_ready in_opcode in_now_time
//            in_period_seconds                                 to block
//   out      out_valid out_ready out_period_count
//            out_window_total                                  from block
//
// From acceptance, clear goes straight to ST_FIN and count through ST_CNT to ST_FIN;
// advance steps through ST_ADV one bucket per whole unit that elapsed (an advance that
// restarts the window takes the clear path) and query steps through ST_QRY one bucket
// per bucket summed (at most BUCKETS), each then passing ST_FIN, which registers
// out_valid; each step uses the one bucket RAM read port and one adder. The block takes
// no new transaction while one is in work or while a result waits unaccepted.
// Reset clears all buckets at once through per-entry valid flags.
module bucketed_sliding_window_counter_core
  import bswc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [TIME_W-1:0]  in_now_time,
  input  logic [TIME_W-1:0]  in_period_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TOTAL_W-1:0] out_period_count,
  output logic [TOTAL_W-1:0] out_window_total
);

  state_t              state_r, state_nxt;
  logic [TIME_W-1:0]   base_r, base_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [TOTAL_W-1:0]  sum_r, sum_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   qaddr_r, qaddr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   paddr_r;
  logic                rvalid_r;
  logic [BUCKETS-1:0]  valid_r, valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]  out_period_r, out_period_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [BUCKET_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [BUCKET_W-1:0] ram_rdata;

  logic                accept;
  logic [TIME_W-1:0]   elapsed;
  logic [BUCKET_W-1:0] rd_data_eff;
  logic [ADDR_W-1:0]   head_dec;
  logic [ADDR_W-1:0]   qaddr_inc;
  logic                rem_ge_unit;

  bswc_ram #(
    .WIDTH (BUCKET_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready         = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_period_count = out_period_r;
  assign out_window_total = out_total_r;

  assign elapsed     = in_now_time - base_r;
  assign rd_data_eff = rvalid_r ? ram_rdata : '0;
  assign head_dec    = (head_r == '0) ? LAST_ADDR : head_r - 1'b1;
  assign qaddr_inc   = (qaddr_r == LAST_ADDR) ? '0 : qaddr_r + 1'b1;
  assign rem_ge_unit = (rem_r >= UNIT_T);

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    total_nxt      = total_r;
    sum_nxt        = sum_r;
    rem_nxt        = rem_r;
    head_nxt       = head_r;
    qaddr_nxt      = qaddr_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = 1'b0;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r;
    out_period_nxt = out_period_r;
    out_total_nxt  = out_total_r;
    ram_we         = 1'b0;
    ram_waddr      = head_r;
    ram_wdata      = rd_data_eff + 1'b1;
    ram_raddr      = head_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sum_nxt = '0;
          unique case (op_t'(in_opcode))
            OP_CLEAR: begin
              base_nxt  = in_now_time;
              total_nxt = '0;
              valid_nxt = '0;
              state_nxt = ST_FIN;
            end
            OP_ADVANCE: begin
              if ((in_now_time < base_r) || (elapsed >= WIN_SPAN)) begin
                base_nxt  = in_now_time;
                total_nxt = '0;
                valid_nxt = '0;
                state_nxt = ST_FIN;
              end else begin
                rem_nxt   = elapsed;
                state_nxt = ST_ADV;
              end
            end
            OP_COUNT: begin
              pend_nxt  = 1'b1;
              state_nxt = ST_CNT;
            end
            OP_QUERY: begin
              rem_nxt   = in_period_seconds;
              cnt_nxt   = '0;
              qaddr_nxt = head_r;
              state_nxt = ST_QRY;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADV: begin
        if (pend_r) begin
          total_nxt          = total_r - TOTAL_W'(rd_data_eff);
          valid_nxt[paddr_r] = 1'b0;
        end
        if (rem_ge_unit) begin
          ram_raddr = head_dec;
          head_nxt  = head_dec;
          rem_nxt   = rem_r - UNIT_T;
          base_nxt  = base_r + UNIT_T;
          pend_nxt  = 1'b1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_QRY: begin
        if (pend_r) begin
          sum_nxt = sum_r + TOTAL_W'(rd_data_eff);
        end
        if ((rem_r != '0) && (cnt_r != BUCKETS_C)) begin
          ram_raddr = qaddr_r;
          qaddr_nxt = qaddr_inc;
          cnt_nxt   = cnt_r + 1'b1;
          rem_nxt   = rem_ge_unit ? rem_r - UNIT_T : '0;
          pend_nxt  = 1'b1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_CNT: begin
        ram_we            = 1'b1;
        valid_nxt[head_r] = 1'b1;
        total_nxt         = total_r + 1'b1;
        state_nxt         = ST_FIN;
      end
      ST_FIN: begin
        out_valid_nxt  = 1'b1;
        out_period_nxt = sum_r;
        out_total_nxt  = total_r;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      total_r     <= '0;
      head_r      <= '0;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      total_r     <= total_nxt;
      head_r      <= head_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r        <= sum_nxt;
    rem_r        <= rem_nxt;
    qaddr_r      <= qaddr_nxt;
    cnt_r        <= cnt_nxt;
    paddr_r      <= ram_raddr;
    rvalid_r     <= valid_r[ram_raddr];
    out_period_r <= out_period_nxt;
    out_total_r  <= out_total_nxt;
  end

endmodule

// ===== src/bswc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bswc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bswc_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the bucketed sliding window counter and their binding.
module bswc_checker
  import bswc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_opcode,
  input logic [TIME_W-1:0]  in_now_time,
  input logic [TIME_W-1:0]  in_period_seconds,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TOTAL_W-1:0] out_period_count,
  input logic [TOTAL_W-1:0] out_window_total
);

  op_t last_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_op_r <= OP_CLEAR;
    end else if (in_valid && in_ready) begin
      last_op_r <= op_t'(in_opcode);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_period_count)
      && $stable(out_window_total))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block not busy after a transaction was accepted");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while a result is stalled");

  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (last_op_r != OP_QUERY) |-> out_period_count == '0)
    else $error("nonzero period count for a non-query transaction");

endmodule

bind bucketed_sliding_window_counter_core bswc_checker u_bswc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bucketed_sliding_window_counter_core with a
// predicting scoreboard, random handshake idling and a directed corner-case phase.
module testbench;
  import bswc_pkg::*;

  typedef struct {
    logic [TOTAL_W-1:0] period;
    logic [TOTAL_W-1:0] total;
  } window_result_t;

  class rate_window_tracker;
    logic [BUCKET_W-1:0] bucket [BUCKETS];
    logic [TOTAL_W-1:0]  total;
    logic [TIME_W-1:0]   base;
    window_result_t      expected [$];
    int                  mismatches;
    int                  checked;
    int                  op_seen [4];
    int                  window_resets;

    function new();
      wipe('0);
      mismatches    = 0;
      checked       = 0;
      window_resets = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void wipe(logic [TIME_W-1:0] now);
      base  = now;
      total = '0;
      foreach (bucket[i]) bucket[i] = '0;
    endfunction

    function void note_transaction(op_t op, logic [TIME_W-1:0] now,
                                   logic [TIME_W-1:0] secs);
      logic [TOTAL_W-1:0] period_sum;
      logic [TIME_W-1:0]  units;
      logic [TIME_W:0]    span;
      int                 shift;
      window_result_t     res;
      period_sum = '0;
      op_seen[int'(op)]++;
      case (op)
        OP_CLEAR: begin
          wipe(now);
        end
        OP_ADVANCE: begin
          units = (now - base) / UNIT_T;
          if (now < base || units >= BUCKETS) begin
            wipe(now);
            window_resets++;
          end else if (units != 0) begin
            shift = int'(units);
            for (int i = BUCKETS - shift; i < BUCKETS; i++) total = total - bucket[i];
            for (int i = BUCKETS - 1; i >= shift; i--) bucket[i] = bucket[i - shift];
            for (int i = 0; i < shift; i++) bucket[i] = '0;
            base = base + units * UNIT_T;
          end
        end
        OP_COUNT: begin
          bucket[0] = bucket[0] + 1'b1;
          total     = total + 1'b1;
        end
        default: begin
          span = secs;
          span = (span + UNIT_SECONDS - 1) / UNIT_SECONDS;
          if (span > BUCKETS) span = BUCKETS;
          for (int i = 0; i < int'(span); i++) period_sum = period_sum + bucket[i];
        end
      endcase
      res.period = period_sum;
      res.total  = total;
      expected.push_back(res);
    endfunction

    function void check_result(logic [TOTAL_W-1:0] period, logic [TOTAL_W-1:0] tot);
      window_result_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: period_count %0d window_total %0d", period, tot);
        return;
      end
      want = expected.pop_front();
      checked++;
      if (period !== want.period || tot !== want.total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch on result %0d: period_count exp %0d got %0d, %s %0d got %0d",
                   checked, want.period, period, "window_total exp", want.total, tot);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [TIME_W-1:0]  in_now_time;
  logic [TIME_W-1:0]  in_period_seconds;
  logic               out_valid;
  logic               out_ready;
  logic [TOTAL_W-1:0] out_period_count;
  logic [TOTAL_W-1:0] out_window_total;

  rate_window_tracker tracker = new();
  bit                 tx_idle_en;
  bit                 rx_stall_en;
  int                 burst_left = 0;

  bucketed_sliding_window_counter_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_now_time       (in_now_time),
    .in_period_seconds (in_period_seconds),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_period_count  (out_period_count),
    .out_window_total  (out_window_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_op(input op_t op, input logic [TIME_W-1:0] now,
                         input logic [TIME_W-1:0] secs);
    int gap;
    gap = 0;
    if (tx_idle_en) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 6);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_now_time       <= now;
    in_period_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    tracker.note_transaction(op, now, secs);
  endtask

  initial begin
    int  hold;
    bit  rx_on;
    hold      = 0;
    rx_on     = 1'b1;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        tracker.check_result(out_period_count, out_window_total);
      if (!rx_stall_en) begin
        out_ready <= 1'b1;
      end else begin
        if (hold == 0) begin
          rx_on = !rx_on;
          hold  = rx_on ? $urandom_range(1, 10) : $urandom_range(1, 6);
        end
        hold--;
        out_ready <= rx_on;
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] wall_clock;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] secs;
    int                pick;
    in_valid          <= 1'b0;
    in_opcode         <= OP_CLEAR;
    in_now_time       <= '0;
    in_period_seconds <= '0;
    rst_n             <= 1'b0;
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_op(OP_QUERY, 32'hFFFF_FFFF, 32'd0);
    repeat (3) send_op(OP_COUNT, 32'h0, 32'hFFFF_FFFF);
    send_op(OP_QUERY, 32'h0, 32'd1);
    send_op(OP_ADVANCE, 32'd63, 32'h0);
    send_op(OP_ADVANCE, 32'd64, 32'h0);
    send_op(OP_COUNT, 32'h0, 32'h0);
    send_op(OP_QUERY, 32'h0, 32'd64);
    send_op(OP_QUERY, 32'h0, 32'd65);
    send_op(OP_QUERY, 32'h0, 32'hFFFF_FFFF);
    send_op(OP_ADVANCE, 32'd4096, 32'h0);
    send_op(OP_QUERY, 32'h0, 32'd4096);
    send_op(OP_ADVANCE, 32'd8192, 32'h0);
    send_op(OP_COUNT, 32'h0, 32'h0);
    send_op(OP_ADVANCE, 32'd0, 32'h0);
    send_op(OP_CLEAR, 32'hFFFF_FFC0, 32'h0);
    send_op(OP_COUNT, 32'h0, 32'h0);
    send_op(OP_ADVANCE, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_QUERY, 32'h0, 32'hFFFF_FFC1);
    send_op(OP_ADVANCE, 32'd5, 32'h0);
    send_op(OP_CLEAR, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_CLEAR, 32'h0, 32'h0);

    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    send_op(OP_CLEAR, 32'd1000, 32'h0);
    repeat (20) send_op(OP_COUNT, $urandom(), $urandom());
    send_op(OP_QUERY, 32'h0, 32'd64);
    send_op(OP_ADVANCE, 32'd1064, 32'h0);
    send_op(OP_QUERY, 32'h0, 32'd128);
    send_op(OP_ADVANCE, 32'd5096, 32'h0);
    send_op(OP_COUNT, 32'h0, 32'h0);
    send_op(OP_QUERY, 32'h0, 32'hFFFF_FFFF);
    send_op(OP_CLEAR, 32'd0, 32'h0);

    wall_clock = '0;
    for (int n = 0; n < 700; n++) begin
      if (n % 120 == 0) begin
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
      end else if (n % 120 == 90) begin
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_op(OP_COUNT, $urandom(), $urandom());
      end else if (pick < 60) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) secs = $urandom_range(0, 4200);
        else if (pick < 8) secs = '0;
        else secs = $urandom();
        send_op(OP_QUERY, $urandom(), secs);
      end else if (pick < 90) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) wall_clock = wall_clock + $urandom_range(0, 200);
        else if (pick < 7) wall_clock = wall_clock + 64 * $urandom_range(0, 65);
        else if (pick < 9) wall_clock = wall_clock + $urandom_range(0, 4500);
        else wall_clock = $urandom();
        send_op(OP_ADVANCE, wall_clock, $urandom());
      end else begin
        stamp = ($urandom_range(0, 4) == 0) ? $urandom() : wall_clock;
        wall_clock = stamp;
        send_op(OP_CLEAR, stamp, $urandom());
      end
    end

    in_valid <= 1'b0;
    while (tracker.expected.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (tracker.expected.size() != 0)
      $display("%0d expected results never arrived", tracker.expected.size());
    $display("Checked %0d results: %0d clear, %0d advance, %0d count, %0d query.",
             tracker.checked, tracker.op_seen[0], tracker.op_seen[1],
             tracker.op_seen[2], tracker.op_seen[3]);
    $display("Advance restarted the window %0d times.", tracker.window_resets);
    if (tracker.mismatches == 0 && tracker.expected.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding.", tracker.expected.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule
